/* rtl/core/i2c_master_sensor_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// I2C sensor sequencer assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_SENSOR_SEQUENCER_MACROS_SVH
`define I2C_MASTER_SENSOR_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define I2CMS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// I2C sensor sequencer package
// Word types, bus phase and transaction step codes, timing constants.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // Command codes carried in each input word
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEVICE_ADDRESS      = 2'd0;
   localparam logic [1:0] CSR_ACK_POLL_LIMIT      = 2'd1;
   localparam logic [1:0] CSR_ADDRESS_RETRY_LIMIT = 2'd2;

   // Configuration reset values
   localparam logic [6:0] DEVICE_ADDRESS_RST      = 7'd35;
   localparam logic [7:0] ACK_POLL_LIMIT_RST      = 8'd250;
   localparam logic [7:0] ADDRESS_RETRY_LIMIT_RST = 8'd100;

   // Phase lengths in ticks
   localparam logic [2:0] START_TICKS  = 3'd4;
   localparam logic [2:0] STOP_TICKS   = 3'd4;
   localparam logic [2:0] BIT_TICKS    = 3'd2;
   localparam logic [2:0] ACK_TICKS    = 3'd1;
   localparam logic [2:0] MACK_TICKS   = 3'd2;
   localparam logic [3:0] BYTE_BITS    = 4'd8;

   typedef enum logic [14:0] {
      PH_IDLE    = 15'h0001,
      PH_ST_A    = 15'h0002,
      PH_ST_B    = 15'h0004,
      PH_TX_LO   = 15'h0008,
      PH_TX_HI   = 15'h0010,
      PH_TX_TL   = 15'h0020,
      PH_AK_REL  = 15'h0040,
      PH_AK_CLK  = 15'h0080,
      PH_AK_POLL = 15'h0100,
      PH_SP_A    = 15'h0200,
      PH_SP_B    = 15'h0400,
      PH_RX_LO   = 15'h0800,
      PH_RX_HI   = 15'h1000,
      PH_MA_LO   = 15'h2000,
      PH_MA_HI   = 15'h4000
   } phase_type;

   typedef enum logic [11:0] {
      SQ_W_START  = 12'h001,
      SQ_W_ADDR   = 12'h002,
      SQ_W_ACK    = 12'h004,
      SQ_W_CMD    = 12'h008,
      SQ_W_CMDACK = 12'h010,
      SQ_W_STOP   = 12'h020,
      SQ_R_START  = 12'h040,
      SQ_R_ADDR   = 12'h080,
      SQ_R_ACK    = 12'h100,
      SQ_R_HI     = 12'h200,
      SQ_R_LO     = 12'h400,
      SQ_R_STOP   = 12'h800
   } step_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] command_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_drive_low;
      logic        busy_res;
      logic        done_res;
      logic        ack_missing;
      logic [15:0] light_value;
   } rsp_type;

   typedef struct packed {
      logic [6:0] device_address;
      logic [7:0] ack_poll_limit;
      logic [7:0] address_retry_limit;
   } cfg_type;

endpackage

/* rtl/core/i2cms_csr.sv */
// ----------------------------------------------------------------------------
// I2C sensor sequencer configuration registers
// Write-only register file for address, poll limit and retry limit.
// ----------------------------------------------------------------------------
module i2cms_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output i2cms_pkg::cfg_type  cfg
);
   import i2cms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:      cfg_in.device_address      = csr_wdata[6:0];
            CSR_ACK_POLL_LIMIT:      cfg_in.ack_poll_limit      = csr_wdata;
            CSR_ADDRESS_RETRY_LIMIT: cfg_in.address_retry_limit = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address      <= DEVICE_ADDRESS_RST;
         cfg_ff.ack_poll_limit      <= ACK_POLL_LIMIT_RST;
         cfg_ff.address_retry_limit <= ADDRESS_RETRY_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/i2cms_seq.sv */
// ----------------------------------------------------------------------------
// I2C sensor sequencer bus engine
// Phase and transaction state, advanced by one tick word per step.
// ----------------------------------------------------------------------------
module i2cms_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2cms_pkg::req_type  req,
   input  i2cms_pkg::cfg_type  cfg,
   output i2cms_pkg::rsp_type  rsp
);
   import i2cms_pkg::*;

   phase_type   phase_ff, phase_in;
   step_type    step_ff, step_in;
   logic [2:0]  delay_ff, delay_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  poll_ff, poll_in;
   logic [7:0]  retries_ff, retries_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] meas_ff, meas_in;
   logic        tmo_ff, tmo_in;

   logic        data_low;
   logic        advance;
   logic        finished;
   logic        scl;
   logic        sda_low;
   logic [2:0]  delay_inc;
   logic [7:0]  addr;

   assign addr = {cfg.device_address, 1'b0};

   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      delay_in   = delay_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      poll_in    = poll_ff;
      retries_in = retries_ff;
      pend_in    = pend_ff;
      hold_in    = hold_ff;
      meas_in    = meas_ff;
      tmo_in     = tmo_ff;
      advance    = 1'b0;
      finished   = 1'b0;
      scl        = 1'b1;
      sda_low    = 1'b0;
      data_low   = ~shift_ff[7];

      // start a transaction when idle; commands are dropped while busy
      if (phase_ff == PH_IDLE && (req.command == CMD_WRITE || req.command == CMD_READ)) begin
         tmo_in   = 1'b0;
         delay_in = 3'd0;
         phase_in = PH_ST_A;
         if (req.command == CMD_WRITE) begin
            pend_in    = req.command_byte;
            retries_in = cfg.address_retry_limit;
            step_in    = SQ_W_START;
         end else begin
            step_in = SQ_R_START;
         end
      end

      case (phase_in)
         PH_ST_A:             begin scl = 1'b1; sda_low = 1'b0;     end
         PH_ST_B:             begin scl = 1'b1; sda_low = 1'b1;     end
         PH_TX_LO, PH_TX_TL:  begin scl = 1'b0; sda_low = data_low; end
         PH_TX_HI:            begin scl = 1'b1; sda_low = data_low; end
         PH_AK_REL, PH_RX_LO: begin scl = 1'b0; sda_low = 1'b0;     end
         PH_SP_A:             begin scl = 1'b0; sda_low = 1'b1;     end
         PH_MA_LO:  begin scl = 1'b0; sda_low = (step_in == SQ_R_HI); end
         PH_MA_HI:  begin scl = 1'b1; sda_low = (step_in == SQ_R_HI); end
         default:             begin scl = 1'b1; sda_low = 1'b0;     end
      endcase

      delay_inc = delay_in + 3'd1;

      case (phase_in)
         PH_ST_A: begin
            delay_in = delay_inc;
            if (delay_inc >= START_TICKS) begin
               delay_in = 3'd0;
               phase_in = PH_ST_B;
            end
         end
         PH_ST_B: begin
            delay_in = delay_inc;
            if (delay_inc >= START_TICKS) begin
               delay_in = 3'd0;
               advance  = 1'b1;
            end
         end
         PH_TX_LO: begin
            delay_in = delay_inc;
            if (delay_inc >= BIT_TICKS) begin
               delay_in = 3'd0;
               phase_in = PH_TX_HI;
            end
         end
         PH_TX_HI: begin
            delay_in = delay_inc;
            if (delay_inc >= BIT_TICKS) begin
               delay_in = 3'd0;
               phase_in = PH_TX_TL;
            end
         end
         PH_TX_TL: begin
            delay_in = delay_inc;
            if (delay_inc >= BIT_TICKS) begin
               delay_in = 3'd0;
               shift_in = {shift_in[6:0], 1'b0};
               bit_in   = bit_in + 4'd1;
               if (bit_in >= BYTE_BITS) begin
                  advance = 1'b1;
               end else begin
                  phase_in = PH_TX_LO;
               end
            end
         end
         PH_AK_REL: begin
            delay_in = delay_inc;
            if (delay_inc >= ACK_TICKS) begin
               delay_in = 3'd0;
               phase_in = PH_AK_CLK;
            end
         end
         PH_AK_CLK: begin
            poll_in  = 8'd0;
            delay_in = delay_inc;
            if (delay_inc >= ACK_TICKS) begin
               delay_in = 3'd0;
               phase_in = PH_AK_POLL;
            end
         end
         PH_AK_POLL: begin
            if (!req.sda_in) begin
               advance = 1'b1;
            end else if (poll_in >= cfg.ack_poll_limit) begin
               tmo_in   = 1'b1;
               delay_in = 3'd0;
               phase_in = PH_SP_A;
            end else begin
               poll_in = poll_in + 8'd1;
            end
         end
         PH_SP_A: begin
            delay_in = delay_inc;
            if (delay_inc >= STOP_TICKS) begin
               delay_in = 3'd0;
               phase_in = PH_SP_B;
            end
         end
         PH_SP_B: begin
            delay_in = delay_inc;
            if (delay_inc >= STOP_TICKS) begin
               delay_in = 3'd0;
               advance  = 1'b1;
            end
         end
         PH_RX_LO: begin
            delay_in = delay_inc;
            if (delay_inc >= BIT_TICKS) begin
               delay_in = 3'd0;
               phase_in = PH_RX_HI;
            end
         end
         PH_RX_HI: begin
            shift_in = {shift_in[6:0], req.sda_in};
            bit_in   = bit_in + 4'd1;
            delay_in = 3'd0;
            phase_in = (bit_in >= BYTE_BITS) ? PH_MA_LO : PH_RX_LO;
         end
         PH_MA_LO: begin
            delay_in = delay_inc;
            if (delay_inc >= MACK_TICKS) begin
               delay_in = 3'd0;
               phase_in = PH_MA_HI;
            end
         end
         PH_MA_HI: begin
            delay_in = delay_inc;
            if (delay_inc >= MACK_TICKS) begin
               delay_in = 3'd0;
               advance  = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // next bus primitive once the current one has finished
      if (advance) begin
         case (step_in)
            SQ_W_START: begin
               step_in = SQ_W_ADDR; shift_in = addr; bit_in = 4'd0; phase_in = PH_TX_LO;
            end
            SQ_W_ADDR: begin
               step_in = SQ_W_ACK; poll_in = 8'd0; phase_in = PH_AK_REL;
            end
            SQ_W_ACK: begin
               // after a timeout stop, retry the address while attempts remain
               if (phase_in == PH_SP_B && retries_in != 8'd0) begin
                  retries_in = retries_in - 8'd1;
                  step_in    = SQ_W_START;
                  phase_in   = PH_ST_A;
               end else begin
                  step_in  = SQ_W_CMD;
                  shift_in = pend_in;
                  bit_in   = 4'd0;
                  phase_in = PH_TX_LO;
               end
            end
            SQ_W_CMD: begin
               step_in = SQ_W_CMDACK; poll_in = 8'd0; phase_in = PH_AK_REL;
            end
            SQ_W_CMDACK: begin
               step_in = SQ_W_STOP; phase_in = PH_SP_A;
            end
            SQ_R_START: begin
               step_in  = SQ_R_ADDR;
               shift_in = {addr[7:1], 1'b1};
               bit_in   = 4'd0;
               phase_in = PH_TX_LO;
            end
            SQ_R_ADDR: begin
               step_in = SQ_R_ACK; poll_in = 8'd0; phase_in = PH_AK_REL;
            end
            SQ_R_ACK: begin
               step_in = SQ_R_HI; shift_in = 8'd0; bit_in = 4'd0; phase_in = PH_RX_LO;
            end
            SQ_R_HI: begin
               hold_in  = shift_in;
               step_in  = SQ_R_LO;
               shift_in = 8'd0;
               bit_in   = 4'd0;
               phase_in = PH_RX_LO;
            end
            SQ_R_LO: begin
               meas_in  = {hold_in, shift_in};
               step_in  = SQ_R_STOP;
               phase_in = PH_SP_A;
            end
            default: begin
               // final stop done
               phase_in = PH_IDLE;
               finished = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         step_ff    <= SQ_W_START;
         delay_ff   <= 3'd0;
         bit_ff     <= 4'd0;
         shift_ff   <= 8'd0;
         poll_ff    <= 8'd0;
         retries_ff <= 8'd0;
         pend_ff    <= 8'd0;
         hold_ff    <= 8'd0;
         meas_ff    <= 16'd0;
         tmo_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         delay_ff   <= delay_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         poll_ff    <= poll_in;
         retries_ff <= retries_in;
         pend_ff    <= pend_in;
         hold_ff    <= hold_in;
         meas_ff    <= meas_in;
         tmo_ff     <= tmo_in;
      end
   end

   always_comb begin
      rsp.scl_level     = scl;
      rsp.sda_drive_low = sda_low;
      rsp.busy_res      = (phase_in != PH_IDLE);
      rsp.done_res      = finished;
      rsp.ack_missing   = finished & tmo_in;
      rsp.light_value   = meas_in;
   end

endmodule

/* rtl/core/i2c_master_sensor_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master sensor sequencer
// Tick-driven I2C master running a command write or a two-byte measurement read.
// ----------------------------------------------------------------------------
// Every input word is one bus tick carrying the sampled SDA level and an
// optional command (write the command byte, or read a 16-bit measurement);
// every input word yields exactly one result word with the SCL level and SDA
// pull-down for that tick, busy/done flags, an acknowledge-timeout flag on the
// done tick and the last measurement. One word is taken per clock cycle
// sustained while rsp_ready is high; a word's result is presented once the
// word has been held in the input register and then stepped through the
// bus engine into the result register. The rate is set by the step of the
// bus engine state, which a word updates before the next word is stepped.
// Commands arriving while busy are dropped.
// Configuration writes are taken whenever csr_we is high and apply to the
// next word stepped.
// ----------------------------------------------------------------------------
`include "i2c_master_sensor_sequencer_macros.svh"

module i2c_master_sensor_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cms_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cms_pkg::rsp_type  rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata
);
   import i2cms_pkg::*;

   cfg_type cfg;
   rsp_type step_rsp;

   // input word register
   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff;

   // result word register
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff;

   logic    req_take;
   logic    step_en;

   // step the held word whenever the result register is free or draining
   assign step_en   = in_vld_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | step_en;
   assign req_take  = req_valid & req_ready;

   assign in_vld_in  = req_take | (in_vld_ff & ~step_en);
   assign out_vld_in = step_en | (out_vld_ff & ~rsp_ready);

   i2cms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cms_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload: hold unless a new word is loaded
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   `I2CMS_ASSERT_NEXT(a_step_fills_output, step_en, out_vld_ff,
                      "stepped word did not reach the result register")
   `I2CMS_ASSERT_NEXT(a_take_fills_input, req_take, in_vld_ff,
                      "accepted word did not reach the input register")
   `I2CMS_ASSERT_NEXT(a_stall_holds_input, in_vld_ff && !step_en, in_vld_ff,
                      "held input word dropped without being stepped")

endmodule
